FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// concurrent assertion helpers, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_AT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("forbidden condition");
`else
`define ASSERT_AT(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

FILE: rtl/trm_pkg.sv
// ----------------------------------------------------------------------------
// trm_pkg
// shared constants of the tandem repeat trim map
// ----------------------------------------------------------------------------
`default_nettype none
package trm_pkg;
  localparam int unsigned HistDepth = 256;
  localparam int unsigned HistAw    = 8;
  localparam logic ActPush  = 1'b0;
  localparam logic ActDrain = 1'b1;
endpackage
`default_nettype wire

FILE: rtl/tandem_repeat_trim_map_unit.sv
// ----------------------------------------------------------------------------
// tandem_repeat_trim_map_unit
// streams bases in, emits left and right tandem repeat trims per position
// ----------------------------------------------------------------------------
// usage:
//   slave channel: tuser is the action (0 push a base, 1 drain), tdata the
//   base. a push stores the base; once 273 more bases follow position q, that
//   push also emits q. each drain closes the sequence and emits the next
//   pending position, with tlast on the final one.
//   master channel: tdata holds left trim (low byte) and right trim.
// operation:
//   a request that emits nothing leaves the unit idle. an emitting request runs a
//   single byte comparator over periods 1..MAX_PERIOD, comparing base pairs through
//   the two-port base memory (request, then check), then scans the history
//   entries (request, then check) for the right trim. s_tready is low meanwhile.
// reset: all counters and flags clear; memories need no clearing.
// stall: a result waits in the output register; the next request is taken,
//   but a new result is held until the previous one is taken.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module tandem_repeat_trim_map_unit #(
  parameter int unsigned MAX_PERIOD   = 18,
  parameter int unsigned TRIM_CAP     = 255,
  parameter int unsigned WINDOW_DEPTH = 512
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // base
  input  wire logic        s_axis_tuser,   // action
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [15:0] m_axis_tdata,   // left trim, right trim
  output logic             m_axis_tlast    // last
);
  localparam int unsigned Aw   = $clog2(WINDOW_DEPTH);
  localparam int unsigned Sw   = $clog2(MAX_PERIOD + 1);
  localparam int unsigned Pw   = $clog2(TRIM_CAP + MAX_PERIOD + 1);
  localparam int unsigned Look = TRIM_CAP + MAX_PERIOD;

  typedef enum logic [3:0] {
    StIdle, StCmpReq, StCmpChk, StPerEnd, StHistWr, StScanReq, StScanChk, StDone
  } state_e;

  state_e      state_q;
  logic [31:0] recv_q, emit_q, q_q;
  logic        closed_q, last_q;
  logic [Sw-1:0] s_q, i_q;
  logic [Pw-1:0] prod_q, best_q, j_q;
  logic [7:0]  t_q, run_q, d_q, right_q;
  logic        out_valid_q;
  logic [7:0]  out_left_q, out_right_q;
  logic        out_last_q;

  logic        push_ok, req_acc;
  logic [32:0] b_idx, a_idx;
  logic [32:0] need;
  logic [7:0]  rd_a, rd_b, rd_h;
  logic [7:0]  run_dec, left_v;

  assign req_acc = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == StIdle);
  assign push_ok = (s_axis_tuser == trm_pkg::ActPush) && !closed_q && (recv_q != '1);
  assign need = {1'b0, emit_q} + 33'(Look + 1);
  assign a_idx = {1'b0, q_q} + 33'(j_q);
  assign b_idx = a_idx + 33'(s_q);
  assign run_dec = (run_q == 8'd0) ? 8'd0 : run_q - 8'd1;
  assign left_v = (t_q > run_dec) ? t_q : run_dec;

  trm_base_mem #(.DEPTH(WINDOW_DEPTH)) u_base (
    .clk_i     (clk_i),
    .we_i      (req_acc && push_ok),
    .waddr_i   (recv_q[Aw-1:0]),
    .wdata_i   (s_axis_tdata),
    .raddr_a_i (a_idx[Aw-1:0]),
    .raddr_b_i (b_idx[Aw-1:0]),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  logic [31:0] p_idx;
  assign p_idx = q_q - 32'(d_q);

  trm_hist_mem u_hist (
    .clk_i   (clk_i),
    .we_i    (state_q == StHistWr),
    .waddr_i (q_q[trm_pkg::HistAw-1:0]),
    .wdata_i (t_q),
    .raddr_i (p_idx[trm_pkg::HistAw-1:0]),
    .rdata_o (rd_h)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      recv_q      <= '0;
      emit_q      <= '0;
      closed_q    <= 1'b0;
      run_q       <= '0;
      out_valid_q <= 1'b0;
      q_q         <= '0;
      last_q      <= 1'b0;
      s_q         <= '0;
      i_q         <= '0;
      prod_q      <= '0;
      best_q      <= '0;
      j_q         <= '0;
      t_q         <= '0;
      d_q         <= '0;
      right_q     <= '0;
      out_left_q  <= '0;
      out_right_q <= '0;
      out_last_q  <= 1'b0;
    end else begin
      if (out_valid_q && m_axis_tready && (state_q != StDone)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (req_acc) begin
            s_q    <= Sw'(1);
            prod_q <= Pw'(1);
            i_q    <= '0;
            j_q    <= '0;
            best_q <= Pw'(1);
            q_q    <= emit_q;
            if (s_axis_tuser == trm_pkg::ActPush) begin
              last_q <= 1'b0;
              if (push_ok) begin
                recv_q <= recv_q + 32'd1;
                if ({1'b0, recv_q} + 33'd1 >= need) begin
                  state_q <= StCmpReq;
                end
              end
            end else begin
              closed_q <= 1'b1;
              last_q   <= (emit_q + 32'd1 == recv_q);
              if (emit_q < recv_q) begin
                state_q <= StCmpReq;
              end
            end
          end
        end
        StCmpReq: begin
          if ((32'(prod_q) >= 32'(TRIM_CAP)) || (b_idx >= {1'b0, recv_q})) begin
            state_q <= StPerEnd;
          end else begin
            state_q <= StCmpChk;
          end
        end
        StCmpChk: begin
          if (rd_a == rd_b) begin
            j_q <= j_q + Pw'(1);
            if (i_q == s_q - Sw'(1)) begin
              i_q    <= '0;
              prod_q <= prod_q + Pw'(s_q);
            end else begin
              i_q <= i_q + Sw'(1);
            end
            state_q <= StCmpReq;
          end else begin
            state_q <= StPerEnd;
          end
        end
        StPerEnd: begin
          if ((prod_q > Pw'(s_q)) && (prod_q > best_q)) begin
            best_q <= prod_q;
          end
          if (32'(s_q) == 32'(MAX_PERIOD)) begin
            state_q <= StHistWr;
            if ((prod_q > Pw'(s_q)) && (prod_q > best_q)) begin
              t_q <= (32'(prod_q) > 32'(TRIM_CAP)) ? 8'(TRIM_CAP) : prod_q[7:0];
            end else begin
              t_q <= (32'(best_q) > 32'(TRIM_CAP)) ? 8'(TRIM_CAP) : best_q[7:0];
            end
          end else begin
            s_q     <= s_q + Sw'(1);
            prod_q  <= Pw'(s_q) + Pw'(1);
            i_q     <= '0;
            j_q     <= '0;
            state_q <= StCmpReq;
          end
        end
        StHistWr: begin
          run_q   <= left_v;
          right_q <= 8'd1;
          if (q_q < 32'(TRIM_CAP - 1)) begin
            d_q <= q_q[7:0];
            state_q <= (q_q == 32'd0) ? StDone : StScanReq;
          end else begin
            d_q     <= 8'(TRIM_CAP - 1);
            state_q <= StScanReq;
          end
        end
        StScanReq: begin
          state_q <= StScanChk;
        end
        StScanChk: begin
          if (rd_h > d_q) begin
            right_q <= d_q + 8'd1;
            state_q <= StDone;
          end else if (d_q == 8'd1) begin
            state_q <= StDone;
          end else begin
            d_q     <= d_q - 8'd1;
            state_q <= StScanReq;
          end
        end
        StDone: begin
          if (!out_valid_q || m_axis_tready) begin
            out_valid_q <= 1'b1;
            out_left_q  <= run_q;
            out_right_q <= right_q;
            out_last_q  <= last_q;
            emit_q      <= emit_q + 32'd1;
            state_q     <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_right_q, out_left_q};
  assign m_axis_tlast  = out_last_q;

  `ASSERT_AT(a_emit_le_recv, clk_i, rst_ni, emit_q <= recv_q)
  `ASSERT_NEVER(a_last_open, clk_i, rst_ni, m_axis_tvalid && m_axis_tlast && !closed_q)
  `ASSERT_NEVER(a_period_range, clk_i, rst_ni,
    (state_q == StCmpChk) && ((s_q == '0) || (32'(s_q) > 32'(MAX_PERIOD))))
endmodule
`default_nettype wire

FILE: rtl/trm_base_mem.sv
// ----------------------------------------------------------------------------
// trm_base_mem
// base window memory, one write port and two registered read ports
// ----------------------------------------------------------------------------
`default_nettype none
module trm_base_mem #(
  parameter int unsigned DEPTH = 512
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [7:0]               wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic      [7:0]               rdata_a_o,
  output logic      [7:0]               rdata_b_o
);
  logic [7:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end
endmodule
`default_nettype wire

FILE: rtl/trm_hist_mem.sv
// ----------------------------------------------------------------------------
// trm_hist_mem
// per-position trim history, one write port and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none
module trm_hist_mem (
  input  wire logic                       clk_i,
  input  wire logic                       we_i,
  input  wire logic [trm_pkg::HistAw-1:0] waddr_i,
  input  wire logic [7:0]                 wdata_i,
  input  wire logic [trm_pkg::HistAw-1:0] raddr_i,
  output logic      [7:0]                 rdata_o
);
  logic [7:0] mem_q [trm_pkg::HistDepth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire
